>>> rtl/dhv_pkg.sv
// Shared types and constants for the DoIP generic header validator.
// Item structs, verdict and negative-acknowledge codes, payload types and lengths.
// No dependencies.
package dhv_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PROTOCOL_VERSION   = 2'd0,
      CSR_MAX_REQUEST_BYTES  = 2'd1,
      CSR_IGNORE_RESP_UDP    = 2'd2
   } csr_index_type;

   localparam logic [7:0]  PROTOCOL_VERSION_RESET  = 8'h02;
   localparam logic [31:0] MAX_REQUEST_BYTES_RESET = 32'd4095;
   localparam logic        IGNORE_RESP_UDP_RESET   = 1'b0;

   localparam logic [7:0] VERSION_DEFAULT     = 8'hFF;
   localparam logic [7:0] VERSION_DEFAULT_INV = 8'h00;

   localparam logic [15:0] PT_GEN_NACK    = 16'h0000;
   localparam logic [15:0] PT_VID_REQ     = 16'h0001;
   localparam logic [15:0] PT_VID_EID_REQ = 16'h0002;
   localparam logic [15:0] PT_VID_VIN_REQ = 16'h0003;
   localparam logic [15:0] PT_VID_RESP    = 16'h0004;
   localparam logic [15:0] PT_RA_REQ      = 16'h0005;
   localparam logic [15:0] PT_ALIVE_RESP  = 16'h0008;
   localparam logic [15:0] PT_STATUS_REQ  = 16'h4001;
   localparam logic [15:0] PT_STATUS_RESP = 16'h4002;
   localparam logic [15:0] PT_PMODE_REQ   = 16'h4003;
   localparam logic [15:0] PT_PMODE_RESP  = 16'h4004;
   localparam logic [15:0] PT_DIAG_MSG    = 16'h8001;

   localparam logic [31:0] LEN_VID_REQ      = 32'd0;
   localparam logic [31:0] LEN_VID_EID_REQ  = 32'd6;
   localparam logic [31:0] LEN_VID_VIN_REQ  = 32'd17;
   localparam logic [31:0] LEN_RA_REQ_SHORT = 32'd7;
   localparam logic [31:0] LEN_RA_REQ_LONG  = 32'd11;
   localparam logic [31:0] LEN_ALIVE_RESP   = 32'd2;
   localparam logic [31:0] LEN_DIAG_MIN     = 32'd4;
   localparam logic [31:0] LEN_STATUS_REQ   = 32'd0;
   localparam logic [31:0] LEN_PMODE_REQ    = 32'd0;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT = 2'd0,
      VERDICT_NACK   = 2'd1,
      VERDICT_DROP   = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      NACK_BAD_PROTOCOL = 2'd0,
      NACK_UNSUPPORTED  = 2'd1,
      NACK_TOO_LONG     = 2'd2,
      NACK_BAD_LENGTH   = 2'd3
   } nack_code_type;

   typedef struct packed {
      logic        is_tcp;
      logic        conn_registered;
      logic        activation_pending;
      logic [7:0]  version_byte;
      logic [7:0]  inverse_version_byte;
      logic [15:0] payload_kind;
      logic [31:0] payload_len;
   } req_type;

   typedef struct packed {
      verdict_type   verdict;
      nack_code_type nack_code;
   } rsp_type;

endpackage

>>> rtl/doip_header_validator_core.sv
// Each accepted request passes the input register, then the result register.
// Throughput: one item per cycle while rsp_stall is low; an input register and
// a result register hold one item each, so a stalled response still lets one
// more request in. Reset: synchronous, active high; empties both registers and
// loads the configuration defaults (version 2, max length 4095, UDP response
// types rejected). Depends on dhv_pkg.
module doip_header_validator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  dhv_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output dhv_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dhv_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [dhv_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   logic [7:0]       protocol_version_ff;
   logic [31:0]      max_request_bytes_ff;
   logic             ignore_resp_udp_ff;

   logic             in_valid_ff;
   dhv_pkg::req_type in_data_ff;
   logic             out_valid_ff;
   dhv_pkg::rsp_type out_data_ff;
   dhv_pkg::rsp_type out_data_in;

   logic             out_free;
   logic             in_free;

   logic             is_vid;
   logic             version_ok;
   logic             type_ok;
   logic             length_ok;
   logic             too_long;
   logic [15:0]      kind;
   logic [31:0]      len;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         protocol_version_ff  <= dhv_pkg::PROTOCOL_VERSION_RESET;
         max_request_bytes_ff <= dhv_pkg::MAX_REQUEST_BYTES_RESET;
         ignore_resp_udp_ff   <= dhv_pkg::IGNORE_RESP_UDP_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == dhv_pkg::CSR_PROTOCOL_VERSION) begin
            protocol_version_ff <= csr_wdata[7:0];
         end
         if (csr_index == dhv_pkg::CSR_MAX_REQUEST_BYTES) begin
            max_request_bytes_ff <= csr_wdata[31:0];
         end
         if (csr_index == dhv_pkg::CSR_IGNORE_RESP_UDP) begin
            ignore_resp_udp_ff <= csr_wdata[0];
         end
      end
   end

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_free   = !in_valid_ff || out_free;
   assign req_stall = !in_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_free) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   assign kind = in_data_ff.payload_kind;
   assign len  = in_data_ff.payload_len;

   always_comb begin
      is_vid = (kind == dhv_pkg::PT_VID_REQ) || (kind == dhv_pkg::PT_VID_EID_REQ) ||
               (kind == dhv_pkg::PT_VID_VIN_REQ);
      version_ok =
         ((in_data_ff.version_byte == protocol_version_ff) &&
          (in_data_ff.inverse_version_byte == ~protocol_version_ff)) ||
         ((in_data_ff.version_byte == dhv_pkg::VERSION_DEFAULT) &&
          (in_data_ff.inverse_version_byte == dhv_pkg::VERSION_DEFAULT_INV) &&
          is_vid);
      if (in_data_ff.is_tcp) begin
         type_ok = (kind == dhv_pkg::PT_RA_REQ) || (kind == dhv_pkg::PT_ALIVE_RESP) ||
                   (kind == dhv_pkg::PT_DIAG_MSG);
      end else begin
         type_ok = is_vid || (kind == dhv_pkg::PT_STATUS_REQ) ||
                   (kind == dhv_pkg::PT_PMODE_REQ) ||
                   (ignore_resp_udp_ff &&
                    ((kind == dhv_pkg::PT_GEN_NACK) || (kind == dhv_pkg::PT_VID_RESP) ||
                     (kind == dhv_pkg::PT_STATUS_RESP) || (kind == dhv_pkg::PT_PMODE_RESP)));
      end
      unique case (kind)
         dhv_pkg::PT_VID_REQ:     length_ok = (len == dhv_pkg::LEN_VID_REQ);
         dhv_pkg::PT_VID_EID_REQ: length_ok = (len == dhv_pkg::LEN_VID_EID_REQ);
         dhv_pkg::PT_VID_VIN_REQ: length_ok = (len == dhv_pkg::LEN_VID_VIN_REQ);
         dhv_pkg::PT_RA_REQ: begin
            length_ok = (len == dhv_pkg::LEN_RA_REQ_SHORT) ||
                        (len == dhv_pkg::LEN_RA_REQ_LONG);
         end
         dhv_pkg::PT_ALIVE_RESP:  length_ok = (len == dhv_pkg::LEN_ALIVE_RESP);
         dhv_pkg::PT_DIAG_MSG:    length_ok = (len > dhv_pkg::LEN_DIAG_MIN);
         dhv_pkg::PT_STATUS_REQ:  length_ok = (len == dhv_pkg::LEN_STATUS_REQ);
         dhv_pkg::PT_PMODE_REQ:   length_ok = (len == dhv_pkg::LEN_PMODE_REQ);
         default:                 length_ok = 1'b1;
      endcase
      too_long = (len > max_request_bytes_ff);
   end

   always_comb begin
      out_data_in.verdict   = dhv_pkg::VERDICT_ACCEPT;
      out_data_in.nack_code = dhv_pkg::NACK_BAD_PROTOCOL;
      priority if (!version_ok) begin
         out_data_in.verdict   = dhv_pkg::VERDICT_NACK;
         out_data_in.nack_code = dhv_pkg::NACK_BAD_PROTOCOL;
      end else if (in_data_ff.is_tcp && !in_data_ff.conn_registered) begin
         if ((kind == dhv_pkg::PT_RA_REQ) ||
             ((kind == dhv_pkg::PT_ALIVE_RESP) && in_data_ff.activation_pending)) begin
            if (!length_ok) begin
               out_data_in.verdict   = dhv_pkg::VERDICT_NACK;
               out_data_in.nack_code = dhv_pkg::NACK_BAD_LENGTH;
            end
         end else begin
            out_data_in.verdict = dhv_pkg::VERDICT_DROP;
         end
      end else if (!type_ok) begin
         out_data_in.verdict   = dhv_pkg::VERDICT_NACK;
         out_data_in.nack_code = dhv_pkg::NACK_UNSUPPORTED;
      end else if (too_long) begin
         out_data_in.verdict   = dhv_pkg::VERDICT_NACK;
         out_data_in.nack_code = dhv_pkg::NACK_TOO_LONG;
      end else if (!length_ok) begin
         out_data_in.verdict   = dhv_pkg::VERDICT_NACK;
         out_data_in.nack_code = dhv_pkg::NACK_BAD_LENGTH;
      end else begin
         out_data_in.verdict = dhv_pkg::VERDICT_ACCEPT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_free |=> out_valid_ff)
      else $error("checked item did not reach the result register");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled with a free slot");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_data_ff.verdict != dhv_pkg::VERDICT_NACK)
         |-> out_data_ff.nack_code == dhv_pkg::NACK_BAD_PROTOCOL)
      else $error("nonzero code without negative acknowledge");

   a_reset_cfg: assert property (@(posedge clock)
      reset |=> protocol_version_ff == dhv_pkg::PROTOCOL_VERSION_RESET &&
                max_request_bytes_ff == dhv_pkg::MAX_REQUEST_BYTES_RESET)
      else $error("configuration not at defaults after reset");

endmodule
